// ===== design/epwbb_pkg.sv =====
// Package for the EEPROM page write-back buffer: widths, codes and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package epwbb_pkg;

  // Page size in bytes; a power of two from 2 to 32.
  localparam int unsigned PAGE_BYTES = 32;
  localparam int unsigned OFF_W      = $clog2(PAGE_BYTES);
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned TAG_W      = ADDR_W - OFF_W;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned DEV_W      = 7;
  localparam logic [DEV_W-1:0] DEV_RESET = 7'd80;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_FILL  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_READ     = 3'd0,
    K_LOAD     = 3'd1,
    K_WB_START = 3'd2,
    K_WB_BYTE  = 3'd3,
    K_FAIL     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RD_IN   = 2'd0,
    RD_REQ  = 2'd1,
    RD_WB   = 2'd2,
    RD_HELD = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_FILL = 2'd0,
    WR_REQ  = 2'd1,
    WR_HELD = 2'd2
  } wr_sel_e;

  typedef enum logic [1:0] {
    PA_TAG  = 2'd0,
    PA_HELD = 2'd1,
    PA_REQ  = 2'd2
  } pa_sel_e;

  typedef struct packed {
    logic    req_load;
    rd_sel_e rd_sel;
    logic    mem_we;
    wr_sel_e wr_sel;
    logic    set_dirty;
    logic    fill_store;
    logic    fill_done;
    logic    fail;
    logic    miss_hold;
    logic    clear_dirty;
    logic    wb_idx_clr;
    logic    wb_idx_inc;
    logic    out_load;
    kind_e   out_kind;
    pa_sel_e out_pa_sel;
    logic    out_data_rd;
    logic    out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic fill_error;
    logic waiting;
    logic valid;
    logic dirty;
    logic hit;
    logic held_is_write;
    logic fill_last;
    logic wb_last;
    logic req_differs;
    logic held_differs;
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== design/epwbb_dpath.sv =====
// Datapath of the page buffer: page store, tag and flags, held access,
// request and result registers. Driven by epwbb_ctrl; uses epwbb_pkg.
`default_nettype none

module epwbb_dpath import epwbb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        operation_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  input  wire logic [DATA_W-1:0] fill_data_i,
  input  wire logic              fill_error_i,
  input  wire logic              cfg_we_i,
  input  wire logic [DEV_W-1:0]  cfg_wdata_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output logic [2:0]             kind_o,
  output logic [ADDR_W-1:0]      page_address_o,
  output logic [DATA_W-1:0]      data_o,
  output logic                   last_o,
  output logic [DEV_W-1:0]       bus_device_o,
  input  wire ctrl_cmd_t         cmd_i,
  output ctrl_stat_t             stat_o
);

  logic [DATA_W-1:0] mem [PAGE_BYTES];
  logic [DATA_W-1:0] rdata_q;
  logic [OFF_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  op_e               req_op_q;
  logic [ADDR_W-1:0] req_addr_q;
  logic [DATA_W-1:0] req_wdata_q, req_fdata_q;
  logic              req_ferr_q;

  logic              valid_q, valid_d;
  logic              dirty_q, dirty_d;
  logic              waiting_q, waiting_d;
  logic [OFF_W-1:0]  fill_cnt_q, fill_cnt_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic              held_wr_q, held_wr_d;
  logic [ADDR_W-1:0] held_addr_q, held_addr_d;
  logic [DATA_W-1:0] held_data_q, held_data_d;
  logic [OFF_W-1:0]  wb_idx_q, wb_idx_d;
  logic [DEV_W-1:0]  device_q;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q;
  logic [ADDR_W-1:0] out_pa_q, out_pa;
  logic [DATA_W-1:0] out_data_q;
  logic              out_last_q;
  logic [DEV_W-1:0]  out_dev_q;
  logic              out_free;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IN:   rd_addr = address_i[OFF_W-1:0];
      RD_REQ:  rd_addr = req_addr_q[OFF_W-1:0];
      RD_WB:   rd_addr = wb_idx_q;
      RD_HELD: rd_addr = held_addr_q[OFF_W-1:0];
      default: rd_addr = req_addr_q[OFF_W-1:0];
    endcase
    unique case (cmd_i.wr_sel)
      WR_FILL: begin
        wr_addr = fill_cnt_q;
        wr_data = req_fdata_q;
      end
      WR_REQ: begin
        wr_addr = req_addr_q[OFF_W-1:0];
        wr_data = req_wdata_q;
      end
      WR_HELD: begin
        wr_addr = held_addr_q[OFF_W-1:0];
        wr_data = held_data_q;
      end
      default: begin
        wr_addr = fill_cnt_q;
        wr_data = req_fdata_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_op_q    <= op_e'(operation_i);
      req_addr_q  <= address_i;
      req_wdata_q <= write_data_i;
      req_fdata_q <= fill_data_i;
      req_ferr_q  <= fill_error_i;
    end
  end

  always_comb begin
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    waiting_d   = waiting_q;
    fill_cnt_d  = fill_cnt_q;
    tag_d       = tag_q;
    held_wr_d   = held_wr_q;
    held_addr_d = held_addr_q;
    held_data_d = held_data_q;
    wb_idx_d    = wb_idx_q;
    if (cmd_i.fill_store) begin
      fill_cnt_d = fill_cnt_q + OFF_W'(1);
    end
    if (cmd_i.fill_done) begin
      fill_cnt_d = '0;
      waiting_d  = 1'b0;
      valid_d    = 1'b1;
      dirty_d    = 1'b0;
      tag_d      = held_addr_q[ADDR_W-1:OFF_W];
    end
    if (cmd_i.fail) begin
      valid_d    = 1'b0;
      dirty_d    = 1'b0;
      waiting_d  = 1'b0;
      fill_cnt_d = '0;
    end
    if (cmd_i.miss_hold) begin
      valid_d     = 1'b0;
      dirty_d     = 1'b0;
      waiting_d   = 1'b1;
      fill_cnt_d  = '0;
      held_wr_d   = (req_op_q == OP_WRITE);
      held_addr_d = req_addr_q;
      held_data_d = req_wdata_q;
    end
    if (cmd_i.set_dirty) begin
      dirty_d = 1'b1;
    end
    if (cmd_i.clear_dirty) begin
      dirty_d = 1'b0;
    end
    if (cmd_i.wb_idx_clr) begin
      wb_idx_d = '0;
    end else if (cmd_i.wb_idx_inc) begin
      wb_idx_d = wb_idx_q + OFF_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      dirty_q     <= 1'b0;
      waiting_q   <= 1'b0;
      fill_cnt_q  <= '0;
      tag_q       <= '0;
      held_wr_q   <= 1'b0;
      held_addr_q <= '0;
      held_data_q <= '0;
      wb_idx_q    <= '0;
      device_q    <= DEV_RESET;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      waiting_q   <= waiting_d;
      fill_cnt_q  <= fill_cnt_d;
      tag_q       <= tag_d;
      held_wr_q   <= held_wr_d;
      held_addr_q <= held_addr_d;
      held_data_q <= held_data_d;
      wb_idx_q    <= wb_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        device_q <= cfg_wdata_i;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    unique case (cmd_i.out_pa_sel)
      PA_TAG:  out_pa = {tag_q, {OFF_W{1'b0}}};
      PA_HELD: out_pa = {held_addr_q[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
      PA_REQ:  out_pa = {req_addr_q[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
      default: out_pa = {tag_q, {OFF_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_pa_q   <= out_pa;
      out_data_q <= cmd_i.out_data_rd ? rdata_q : '0;
      out_last_q <= cmd_i.out_last;
      out_dev_q  <= device_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign page_address_o = out_pa_q;
  assign data_o         = out_data_q;
  assign last_o         = out_last_q;
  assign bus_device_o   = out_dev_q;

  always_comb begin
    stat_o.op            = req_op_q;
    stat_o.fill_error    = req_ferr_q;
    stat_o.waiting       = waiting_q;
    stat_o.valid         = valid_q;
    stat_o.dirty         = dirty_q;
    stat_o.hit           = valid_q && (tag_q == req_addr_q[ADDR_W-1:OFF_W]);
    stat_o.held_is_write = held_wr_q;
    stat_o.fill_last     = (fill_cnt_q == OFF_W'(PAGE_BYTES - 1));
    stat_o.wb_last       = (wb_idx_q == OFF_W'(PAGE_BYTES - 1));
    stat_o.req_differs   = (rdata_q != req_wdata_q);
    stat_o.held_differs  = (rdata_q != held_data_q);
    stat_o.out_free      = out_free;
  end

`ifndef SYNTHESIS
  a_dirty_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dirty_q |-> valid_q)
    else $error("dirty flag set without a valid page");
  a_no_page_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> !valid_q)
    else $error("page valid while a load is pending");
`endif

endmodule

`default_nettype wire

// ===== design/epwbb_ctrl.sv =====
// Controller of the page buffer: decodes each request and sequences hits,
// write-backs, load requests and fills. Commands epwbb_dpath; uses epwbb_pkg.
`default_nettype none

module epwbb_ctrl import epwbb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire ctrl_stat_t stat_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EVAL     = 3'd1;
  localparam logic [2:0] S_WB_START = 3'd2;
  localparam logic [2:0] S_WB_RD    = 3'd3;
  localparam logic [2:0] S_WB_OUT   = 3'd4;
  localparam logic [2:0] S_LOAD     = 3'd5;
  localparam logic [2:0] S_HELD_RD  = 3'd6;
  localparam logic [2:0] S_HELD_DO  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d           = state_q;
    cmd_o.req_load    = 1'b0;
    cmd_o.rd_sel      = RD_REQ;
    cmd_o.mem_we      = 1'b0;
    cmd_o.wr_sel      = WR_FILL;
    cmd_o.set_dirty   = 1'b0;
    cmd_o.fill_store  = 1'b0;
    cmd_o.fill_done   = 1'b0;
    cmd_o.fail        = 1'b0;
    cmd_o.miss_hold   = 1'b0;
    cmd_o.clear_dirty = 1'b0;
    cmd_o.wb_idx_clr  = 1'b0;
    cmd_o.wb_idx_inc  = 1'b0;
    cmd_o.out_load    = 1'b0;
    cmd_o.out_kind    = K_READ;
    cmd_o.out_pa_sel  = PA_TAG;
    cmd_o.out_data_rd = 1'b0;
    cmd_o.out_last    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.rd_sel = RD_IN;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_EVAL;
        end
      end

      S_EVAL: begin
        if (stat_i.waiting) begin
          if (stat_i.op != OP_FILL) begin
            state_d = S_IDLE;
          end else if (stat_i.fill_error) begin
            if (stat_i.out_free) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_kind   = K_FAIL;
              cmd_o.out_pa_sel = PA_HELD;
              cmd_o.fail       = 1'b1;
              state_d          = S_IDLE;
            end
          end else begin
            cmd_o.mem_we     = 1'b1;
            cmd_o.wr_sel     = WR_FILL;
            cmd_o.fill_store = 1'b1;
            if (stat_i.fill_last) begin
              cmd_o.fill_done = 1'b1;
              state_d         = S_HELD_RD;
            end else begin
              state_d = S_IDLE;
            end
          end
        end else begin
          unique case (stat_i.op)
            OP_FILL: state_d = S_IDLE;
            OP_FLUSH: begin
              state_d = (stat_i.valid && stat_i.dirty) ? S_WB_START : S_IDLE;
            end
            OP_READ, OP_WRITE: begin
              if (stat_i.hit) begin
                if (stat_i.op == OP_WRITE) begin
                  if (stat_i.req_differs) begin
                    cmd_o.mem_we    = 1'b1;
                    cmd_o.wr_sel    = WR_REQ;
                    cmd_o.set_dirty = 1'b1;
                  end
                  state_d = S_IDLE;
                end else if (stat_i.out_free) begin
                  cmd_o.out_load    = 1'b1;
                  cmd_o.out_kind    = K_READ;
                  cmd_o.out_pa_sel  = PA_TAG;
                  cmd_o.out_data_rd = 1'b1;
                  state_d           = S_IDLE;
                end
              end else begin
                state_d = (stat_i.valid && stat_i.dirty) ? S_WB_START : S_LOAD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_WB_START: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = K_WB_START;
          cmd_o.out_pa_sel = PA_TAG;
          cmd_o.out_last   = 1'b0;
          cmd_o.wb_idx_clr = 1'b1;
          state_d          = S_WB_RD;
        end
      end

      S_WB_RD: begin
        cmd_o.rd_sel = RD_WB;
        state_d      = S_WB_OUT;
      end

      S_WB_OUT: begin
        cmd_o.rd_sel = RD_WB;
        if (stat_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_kind    = K_WB_BYTE;
          cmd_o.out_pa_sel  = PA_TAG;
          cmd_o.out_data_rd = 1'b1;
          cmd_o.out_last    = stat_i.wb_last;
          if (stat_i.wb_last) begin
            cmd_o.clear_dirty = 1'b1;
            state_d           = (stat_i.op == OP_FLUSH) ? S_IDLE : S_LOAD;
          end else begin
            cmd_o.wb_idx_inc = 1'b1;
            state_d          = S_WB_RD;
          end
        end
      end

      S_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = K_LOAD;
          cmd_o.out_pa_sel = PA_REQ;
          cmd_o.miss_hold  = 1'b1;
          state_d          = S_IDLE;
        end
      end

      S_HELD_RD: begin
        cmd_o.rd_sel = RD_HELD;
        state_d      = S_HELD_DO;
      end

      S_HELD_DO: begin
        cmd_o.rd_sel = RD_HELD;
        if (stat_i.held_is_write) begin
          if (stat_i.held_differs) begin
            cmd_o.mem_we    = 1'b1;
            cmd_o.wr_sel    = WR_HELD;
            cmd_o.set_dirty = 1'b1;
          end
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_kind    = K_READ;
          cmd_o.out_pa_sel  = PA_TAG;
          cmd_o.out_data_rd = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result register loaded while still occupied");
  a_wb_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB_OUT) && stat_i.out_free && stat_i.wb_last
      |=> (state_q == S_IDLE) || (state_q == S_LOAD))
    else $error("write-back did not end in idle or load");
  a_fill_last_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HELD_RD) |-> stat_i.valid && !stat_i.waiting)
    else $error("held access resumed without a loaded page");
`endif

endmodule

`default_nettype wire

// ===== design/eeprom_page_write_back_buffer_unit.sv =====
// Buffers one EEPROM page of PAGE_BYTES bytes for byte reads and writes. One request at
// a time: a request is taken in idle and decoded the next cycle; a held
// access finishing a load first reads the page store, then completes. A miss
// on a dirty page writes the page back first: a start result, then each byte
// read through the single read port of the page store and then put out,
// then the load request. Results sit in an output register; a stall there
// holds the controller.
// Depends on epwbb_pkg, epwbb_ctrl and epwbb_dpath.
`default_nettype none

module eeprom_page_write_back_buffer_unit import epwbb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [DEV_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  input  wire logic [DATA_W-1:0] fill_data_i,
  input  wire logic              fill_error_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             kind_o,
  output logic [ADDR_W-1:0]      page_address_o,
  output logic [DATA_W-1:0]      data_o,
  output logic                   last_o,
  output logic [DEV_W-1:0]       bus_device_o
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  epwbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  epwbb_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (operation_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .fill_data_i    (fill_data_i),
    .fill_error_i   (fill_error_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .page_address_o (page_address_o),
    .data_o         (data_o),
    .last_o         (last_o),
    .bus_device_o   (bus_device_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

`default_nettype wire
